/* hdl/hmes_pkg.sv */
// shared types, constants and helper functions of the heightmap smoother
package hmes_pkg;

   // payload and register widths
   localparam int MODE_W   = 1;
   localparam int SAMPLE_W = 8;
   localparam int HEIGHT_W = 24;
   localparam int WIDTH_W  = 10;
   localparam int DEPTH_W  = 13;
   localparam int SCALE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_WIDTH_DEFAULT = 512;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_DEPTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

   localparam logic [WIDTH_W-1:0] MAP_WIDTH_RESET    = 10'd256;
   localparam logic [DEPTH_W-1:0] MAP_DEPTH_RESET    = 13'd256;
   localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RESET = 16'd256;

   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 13'd4096;
   localparam int                 DIM_MIN     = 2;

   // item modes
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b0;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 1'b1;

   // results allowed per item
   localparam int BUDGET_W = 2;
   localparam logic [BUDGET_W-1:0] BUDGET_SAMPLE = 2'd2;
   localparam logic [BUDGET_W-1:0] BUDGET_FLUSH  = 2'd1;

   // arithmetic widths
   localparam int SUM_W   = 12;   // up to nine samples
   localparam int PROD_W  = 28;   // sum times scale
   localparam int QUOT_W  = 16;   // mean times scale over full-scale sample
   localparam int DIV_W   = 12;
   localparam int RECIP_W = 31;
   localparam int RECIP_SHIFT = 40;
   localparam int RECIP_PROD_W = PROD_W + RECIP_W;

   localparam int SAMPLE_FULL = 255;
   localparam logic [DIV_W-1:0] DIV_CORNER = 12'(SAMPLE_FULL * 4);
   localparam logic [DIV_W-1:0] DIV_SIDE   = 12'(SAMPLE_FULL * 6);
   localparam logic [DIV_W-1:0] DIV_INNER  = 12'(SAMPLE_FULL * 9);

   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_CORNER = 31'(RECIP_ONE / 64'(DIV_CORNER));
   localparam logic [RECIP_W-1:0] RECIP_SIDE   = 31'(RECIP_ONE / 64'(DIV_SIDE));
   localparam logic [RECIP_W-1:0] RECIP_INNER  = 31'(RECIP_ONE / 64'(DIV_INNER));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_DRAIN,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_EMIT
   } hmes_state_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic issue;
      logic mul1;
      logic mul2;
      logic mul3;
      logic emit;
   } hmes_cmd_type;

   typedef struct packed {
      logic vertex_ready;
      logic tap_last;
      logic out_free;
   } hmes_status_type;

   // 255 times the neighbor count: corner 4, side 6, interior 9
   function automatic logic [DIV_W-1:0] divisor_of(input logic edge_z, input logic edge_x);
      logic [DIV_W-1:0] d;
      if (edge_z && edge_x) d = DIV_CORNER;
      else if (edge_z || edge_x) d = DIV_SIDE;
      else d = DIV_INNER;
      return d;
   endfunction

   function automatic logic [RECIP_W-1:0] recip_of(input logic edge_z, input logic edge_x);
      logic [RECIP_W-1:0] r;
      if (edge_z && edge_x) r = RECIP_CORNER;
      else if (edge_z || edge_x) r = RECIP_SIDE;
      else r = RECIP_INNER;
      return r;
   endfunction

endpackage

/* hdl/hmes_if.sv */
// channel interfaces: sample input, smoothed output and register writes
interface hmes_req_if;
   import hmes_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [SAMPLE_W-1:0] height_sample;
   modport source (output valid, output mode, output height_sample, input ready);
   modport sink   (input valid, input mode, input height_sample, output ready);
endinterface

interface hmes_rsp_if;
   import hmes_pkg::*;
   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] smoothed_height;
   logic                frame_last;
   modport source (output valid, output smoothed_height, output frame_last, input ready);
   modport sink   (input valid, input smoothed_height, input frame_last, output ready);
endinterface

interface hmes_csr_if;
   import hmes_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/heightmap_edge_extend_box_smooth_top.sv */
// top level of the edge-extended 3x3 heightmap smoother
//
//   channel   dir   handshake      payload
//   req_if    in    valid/ready    mode, height_sample
//   rsp_if    out   valid/ready    smoothed_height, frame_last
//   csr_if    in    valid/ready    index, data (ready always high)
//
// an item releases up to two vertices: a sample item up to two, a flush item one
// each vertex reads its nine neighbors one per cycle through the single line
// memory read port, then runs three registered multiply steps and one correction
// synchronous active-high reset clears control state; the line memory is not cleared
// a stalled rsp_if holds the vertex in its output register; the next item is still
// taken, and emitting further vertices waits until that register is free
module heightmap_edge_extend_box_smooth_top #(
   parameter int MAX_WIDTH = hmes_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   hmes_req_if.sink   req_if,
   hmes_rsp_if.source rsp_if,
   hmes_csr_if.sink   csr_if
);
   import hmes_pkg::*;

   hmes_cmd_type    cmd;
   hmes_status_type status;

   hmes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hmes_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_if.mode),
      .req_height_sample   (req_if.height_sample),
      .csr_valid           (csr_if.valid),
      .csr_index           (csr_if.index),
      .csr_data            (csr_if.data),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_smoothed_height (rsp_if.smoothed_height),
      .rsp_frame_last      (rsp_if.frame_last)
   );

   assign csr_if.ready = 1'b1;

endmodule

/* hdl/hmes_ctrl.sv */
// sequencer: accepts items, walks the 3x3 taps and the divide steps per vertex
module hmes_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [hmes_pkg::MODE_W-1:0] req_mode,
   output logic                     req_ready,
   input  hmes_pkg::hmes_status_type status,
   output hmes_pkg::hmes_cmd_type    cmd
);
   import hmes_pkg::*;

   hmes_state_type        state_ff, state_in;
   logic [BUDGET_W-1:0]   budget_ff, budget_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         budget_ff <= '0;
      end else begin
         state_ff  <= state_in;
         budget_ff <= budget_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      budget_in = budget_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in  = ST_CHECK;
               budget_in = (req_mode == MODE_FLUSH) ? BUDGET_FLUSH : BUDGET_SAMPLE;
            end
         end
         ST_CHECK: begin
            if (budget_ff != '0 && status.vertex_ready) state_in = ST_READ;
            else state_in = ST_IDLE;
         end
         ST_READ: begin
            if (status.tap_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in  = ST_CHECK;
               budget_in = budget_ff - 2'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CHECK: cmd.start = (budget_ff != '0) && status.vertex_ready;
         ST_READ:  cmd.issue = 1'b1;
         ST_DRAIN: ;
         ST_MUL1:  cmd.mul1 = 1'b1;
         ST_MUL2:  cmd.mul2 = 1'b1;
         ST_MUL3:  cmd.mul3 = 1'b1;
         ST_EMIT:  cmd.emit = status.out_free;
         default: ;
      endcase
   end

endmodule

/* hdl/hmes_datapath.sv */
// line memory, frame counters, tap accumulator, scaled divide and output register
module hmes_datapath #(
   parameter int MAX_WIDTH = hmes_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hmes_pkg::hmes_cmd_type         cmd,
   output hmes_pkg::hmes_status_type      status,
   input  logic [hmes_pkg::MODE_W-1:0]     req_mode,
   input  logic [hmes_pkg::SAMPLE_W-1:0]   req_height_sample,
   input  logic                          csr_valid,
   input  logic [hmes_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hmes_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [hmes_pkg::HEIGHT_W-1:0]   rsp_smoothed_height,
   output logic                          rsp_frame_last
);
   import hmes_pkg::*;

   localparam int MEM_DEPTH = 4 * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // configuration
   logic [WIDTH_W-1:0] map_width_ff;
   logic [DEPTH_W-1:0] map_depth_ff;
   logic [SCALE_W-1:0] height_scale_ff;
   logic               cfg_restart;

   // frame counters
   logic [WIDTH_W-1:0] in_col_ff, out_x_ff;
   logic [DEPTH_W-1:0] in_row_ff, out_z_ff;

   // tap walk and accumulator
   logic [1:0]          tap_row_ff, tap_col_ff;
   logic                add_en_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [SUM_W-1:0]    sum_ff;

   // divide pipeline
   logic [PROD_W-1:0] prod_ff, back_ff;
   logic [QUOT_W-1:0] q_est_ff;

   // output register
   logic                rsp_valid_ff;
   logic [HEIGHT_W-1:0] rsp_height_ff;
   logic                rsp_last_ff;

   logic [SAMPLE_W-1:0] line_mem [MEM_DEPTH];

   logic [WIDTH_W-1:0] eff_w;
   logic [DEPTH_W-1:0] eff_d;
   logic [DEPTH_W:0]   z_next, vzp, vz;
   logic [WIDTH_W:0]   x_next, vxp, vx;
   logic [DEPTH_W-1:0] need_row, src_row;
   logic [WIDTH_W-1:0] need_col, src_col;
   logic               tap_in;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic               edge_z, edge_x;
   logic [DIV_W-1:0]   divisor;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  remainder;
   logic [QUOT_W-1:0]  q_final;
   logic               last_vertex;
   logic [WIDTH_W:0]   in_col_next;

   // clamped frame size
   always_comb begin
      eff_w = map_width_ff;
      if (map_width_ff < WIDTH_W'(DIM_MIN)) eff_w = WIDTH_W'(DIM_MIN);
      else if (32'(map_width_ff) > MAX_WIDTH) eff_w = WIDTH_W'(MAX_WIDTH);
      eff_d = map_depth_ff;
      if (map_depth_ff < DEPTH_W'(DIM_MIN)) eff_d = DEPTH_W'(DIM_MIN);
      else if (map_depth_ff > DEPTH_LIMIT) eff_d = DEPTH_LIMIT;
   end

   // a vertex is ready once the sample below-right of it (clamped) is in
   always_comb begin
      z_next = {1'b0, out_z_ff} + 14'd1;
      x_next = {1'b0, out_x_ff} + 11'd1;
      need_row = (z_next >= {1'b0, eff_d}) ? eff_d - 13'd1 : z_next[DEPTH_W-1:0];
      need_col = (x_next >= {1'b0, eff_w}) ? eff_w - 10'd1 : x_next[WIDTH_W-1:0];
      status.vertex_ready = (need_row < in_row_ff) ||
                            (need_row == in_row_ff && need_col < in_col_ff);
      status.tap_last = (tap_row_ff == 2'd2) && (tap_col_ff == 2'd2);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // neighbor address, edge rows and columns repeat the last sample
   always_comb begin
      vzp = {1'b0, out_z_ff} + {12'b0, tap_row_ff};
      vxp = {1'b0, out_x_ff} + {9'b0, tap_col_ff};
      vz  = vzp - 14'd1;
      vx  = vxp - 11'd1;
      tap_in = (vzp != '0) && (vzp <= {1'b0, eff_d} + 14'd1) &&
               (vxp != '0) && (vxp <= {1'b0, eff_w} + 11'd1);
      src_row = (vz >= {1'b0, eff_d}) ? eff_d - 13'd1 : vz[DEPTH_W-1:0];
      src_col = (vx >= {1'b0, eff_w}) ? eff_w - 10'd1 : vx[WIDTH_W-1:0];
      rd_addr = ADDR_W'(src_row[1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(src_col);
      wr_addr = ADDR_W'(in_row_ff[1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_ff);
      wr_en   = cmd.accept && (req_mode == MODE_SAMPLE) && (in_row_ff < eff_d);
      in_col_next = {1'b0, in_col_ff} + 11'd1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) line_mem[wr_addr] <= req_height_sample;
      if (cmd.issue) rd_data_ff <= line_mem[rd_addr];
   end

   // divisor from the neighbor count, then floor via reciprocal and one correction
   always_comb begin
      edge_z      = (out_z_ff == '0) || (out_z_ff == eff_d);
      edge_x      = (out_x_ff == '0) || (out_x_ff == eff_w);
      divisor     = divisor_of(edge_z, edge_x);
      recip       = recip_of(edge_z, edge_x);
      remainder   = prod_ff - back_ff;
      q_final     = (remainder >= PROD_W'(divisor)) ? q_est_ff + 16'd1 : q_est_ff;
      last_vertex = (out_z_ff == eff_d) && (out_x_ff == eff_w);
      cfg_restart = csr_valid && (csr_index == REG_MAP_WIDTH ||
                    csr_index == REG_MAP_DEPTH || csr_index == REG_HEIGHT_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff    <= MAP_WIDTH_RESET;
         map_depth_ff    <= MAP_DEPTH_RESET;
         height_scale_ff <= HEIGHT_SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MAP_WIDTH:    map_width_ff    <= csr_data[WIDTH_W-1:0];
            REG_MAP_DEPTH:    map_depth_ff    <= csr_data[DEPTH_W-1:0];
            REG_HEIGHT_SCALE: height_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_x_ff  <= '0;
         out_z_ff  <= '0;
      end else if (cmd.emit && last_vertex) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_x_ff  <= '0;
         out_z_ff  <= '0;
      end else begin
         if (wr_en) begin
            if (in_col_next >= {1'b0, eff_w}) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 13'd1;
            end else begin
               in_col_ff <= in_col_next[WIDTH_W-1:0];
            end
         end
         if (cmd.emit) begin
            if (out_x_ff == eff_w) begin
               out_x_ff <= '0;
               out_z_ff <= out_z_ff + 13'd1;
            end else begin
               out_x_ff <= out_x_ff + 10'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_row_ff <= '0;
         tap_col_ff <= '0;
         add_en_ff  <= 1'b0;
      end else begin
         add_en_ff <= cmd.issue && tap_in;
         if (cmd.start) begin
            tap_row_ff <= '0;
            tap_col_ff <= '0;
         end else if (cmd.issue) begin
            if (tap_col_ff == 2'd2) begin
               tap_col_ff <= '0;
               tap_row_ff <= tap_row_ff + 2'd1;
            end else begin
               tap_col_ff <= tap_col_ff + 2'd1;
            end
         end
      end
   end

   // read data lands in the cycle after the issue
   always_ff @(posedge clock) begin
      if (cmd.start) sum_ff <= '0;
      else if (add_en_ff) sum_ff <= sum_ff + SUM_W'(rd_data_ff);
      if (cmd.mul1) prod_ff <= PROD_W'(sum_ff) * PROD_W'(height_scale_ff);
      if (cmd.mul2) q_est_ff <= QUOT_W'((RECIP_PROD_W'(prod_ff) * RECIP_PROD_W'(recip))
                                        >> RECIP_SHIFT);
      if (cmd.mul3) back_ff <= PROD_W'(q_est_ff) * PROD_W'(divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_height_ff <= HEIGHT_W'(q_final);
         rsp_last_ff   <= last_vertex;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_smoothed_height = rsp_height_ff;
   assign rsp_frame_last      = rsp_last_ff;

endmodule

/* hdl/hmes_checker.sv */
// port-level checks of the heightmap smoother, bound to the top level
module hmes_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hmes_pkg::HEIGHT_W-1:0] rsp_smoothed_height,
   input logic                          rsp_frame_last
);
   import hmes_pkg::*;

   // a pending result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_smoothed_height) && $stable(rsp_frame_last))
      else $error("stalled result changed");

   // one item at a time: input closes right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open again right after an accept");

   // a new result only appears while an item is being worked on
   a_rsp_in_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("result appeared while idle");

endmodule

bind heightmap_edge_extend_box_smooth_top hmes_checker u_hmes_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_smoothed_height (rsp_if.smoothed_height),
   .rsp_frame_last      (rsp_if.frame_last)
);

/* bench/tb_heightmap_edge_extend_box_smooth_top.sv */
// testbench of the heightmap smoother: streams frames, predicts every vertex, checks each result
module tb_heightmap_edge_extend_box_smooth_top;
   import hmes_pkg::*;

   localparam int MAX_W         = MAX_WIDTH_DEFAULT;
   localparam int FULL_SAMPLE   = 255;
   localparam int IDLE_PCT      = 11;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 3000;
   localparam int ITEM_TARGET   = 1950;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic                last;
   } vertex_type;

   logic clock;
   logic reset;

   hmes_req_if req_if();
   hmes_rsp_if rsp_if();
   hmes_csr_if csr_if();

   heightmap_edge_extend_box_smooth_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // predictor state
   bit   [SAMPLE_W-1:0] sample_rows [4][MAX_W];
   logic [WIDTH_W-1:0]  reg_map_width;
   logic [DEPTH_W-1:0]  reg_map_depth;
   logic [SCALE_W-1:0]  reg_height_scale;
   int col_in;
   int row_in;
   int vertex_pos;

   vertex_type expected_vertices[$];
   vertex_type due;
   int mismatches;
   int useful_items;
   int idle_pct;
   int rsp_hold_cycles;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic int row_len();
      int w;
      w = int'(reg_map_width);
      if (w < DIM_MIN) w = DIM_MIN;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int row_count();
      int d;
      d = int'(reg_map_depth);
      if (d < DIM_MIN) d = DIM_MIN;
      if (d > int'(DEPTH_LIMIT)) d = int'(DEPTH_LIMIT);
      return d;
   endfunction

   function automatic bit frame_open();
      return (col_in != 0) || (row_in != 0) || (vertex_pos != 0);
   endfunction

   function automatic logic [HEIGHT_W-1:0] smooth_vertex(input int z, input int x,
                                                         input int w, input int d);
      longint total;
      int n;
      int vz;
      int vx;
      int sr;
      int sc;
      total = 0;
      n = 0;
      for (int dz = -1; dz <= 1; dz++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            vz = z + dz;
            vx = x + dx;
            if (vz >= 0 && vz <= d && vx >= 0 && vx <= w) begin
               // the extra row and column repeat their neighbor
               sr = (vz > d - 1) ? d - 1 : vz;
               sc = (vx > w - 1) ? w - 1 : vx;
               total += longint'(sample_rows[sr % 4][sc]);
               n++;
            end
         end
      end
      return HEIGHT_W'((total * longint'(reg_height_scale)) / longint'(FULL_SAMPLE * n));
   endfunction

   function automatic int release_vertices(input int limit);
      int w;
      int d;
      int total;
      int taken;
      int made;
      int z;
      int x;
      int need;
      vertex_type v;
      w = row_len();
      d = row_count();
      total = (w + 1) * (d + 1);
      taken = row_in * w + col_in;
      made = 0;
      while (made < limit && vertex_pos < total) begin
         z = vertex_pos / (w + 1);
         x = vertex_pos % (w + 1);
         // newest sample that the 3x3 window of this vertex touches
         need = ((z + 1 < d - 1) ? z + 1 : d - 1) * w + ((x + 1 < w - 1) ? x + 1 : w - 1);
         if (need >= taken) break;
         v.height = smooth_vertex(z, x, w, d);
         v.last = (vertex_pos == total - 1);
         expected_vertices.push_back(v);
         made++;
         vertex_pos++;
         if (v.last) begin
            col_in = 0;
            row_in = 0;
            vertex_pos = 0;
            break;
         end
      end
      return made;
   endfunction

   function automatic void take_item(input logic [MODE_W-1:0] m, input logic [SAMPLE_W-1:0] s);
      int w;
      int d;
      int made;
      bit stored;
      w = row_len();
      d = row_count();
      stored = 1'b0;
      if (m == MODE_FLUSH) begin
         made = release_vertices(int'(BUDGET_FLUSH));
      end else begin
         // surplus samples past the last row are dropped
         if (row_in < d) begin
            sample_rows[row_in % 4][col_in] = s;
            stored = 1'b1;
            col_in++;
            if (col_in >= w) begin
               col_in = 0;
               row_in++;
            end
         end
         made = release_vertices(int'(BUDGET_SAMPLE));
      end
      if (stored || made > 0) useful_items++;
   endfunction

   function automatic void apply_register_write(input logic [CSR_IDX_W-1:0] idx,
                                                input logic [CSR_DATA_W-1:0] data);
      bit restart;
      restart = 1'b1;
      case (idx)
         REG_MAP_WIDTH:    reg_map_width = data[WIDTH_W-1:0];
         REG_MAP_DEPTH:    reg_map_depth = data[DEPTH_W-1:0];
         REG_HEIGHT_SCALE: reg_height_scale = data[SCALE_W-1:0];
         default:          restart = 1'b0;
      endcase
      if (restart) begin
         col_in = 0;
         row_in = 0;
         vertex_pos = 0;
      end
   endfunction

   // ---------------- result side ----------------

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_vertices.size() == 0) begin
            $error("smoothed_height: expected none, got %0d", rsp_if.smoothed_height);
            mismatches++;
         end else begin
            due = expected_vertices.pop_front();
            if (rsp_if.smoothed_height !== due.height) begin
               $error("smoothed_height: expected %0d, got %0d",
                      due.height, rsp_if.smoothed_height);
               mismatches++;
            end
            if (rsp_if.frame_last !== due.last) begin
               $error("frame_last: expected %0d, got %0d", due.last, rsp_if.frame_last);
               mismatches++;
            end
         end
      end
   end

   // ends the run when no channel moves for too long
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // ---------------- stimulus helpers ----------------

   // called at a falling edge; valid may still be high from the previous item
   task automatic send_item(input logic [MODE_W-1:0] m, input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= m;
      req_if.height_sample <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      take_item(m, s);
      @(negedge clock);
   endtask

   task automatic send_samples(input int count, input int flush_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < flush_pct) send_item(MODE_FLUSH, 8'($urandom));
         send_item(MODE_SAMPLE, 8'($urandom));
      end
   endtask

   // all samples are in: flushes and surplus samples drive out the rest
   task automatic finish_frame(input int flush_pct);
      while (frame_open())
         send_item(($urandom_range(99) < flush_pct) ? MODE_FLUSH : MODE_SAMPLE, 8'($urandom));
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_vertices.size() != 0) @(negedge clock);
   endtask

   // flushes with nothing ready may still be in flight after the last vertex
   task automatic wait_idle();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      apply_register_write(idx, data);
      @(negedge clock);
   endtask

   task automatic configure(input logic [15:0] w, input logic [15:0] d, input logic [15:0] s);
      write_reg(REG_MAP_WIDTH, w);
      write_reg(REG_MAP_DEPTH, d);
      write_reg(REG_HEIGHT_SCALE, s);
      csr_if.valid <= 1'b0;
   endtask

   task automatic random_config();
      logic [15:0] w;
      logic [15:0] d;
      logic [15:0] s;
      int pick;
      pick = $urandom_range(99);
      if (pick < 6) w = 16'($urandom_range(1));
      else if (pick < 75) w = 16'($urandom_range(8, 2));
      else w = 16'($urandom_range(40, 9));
      w[15:WIDTH_W] = 6'($urandom);
      pick = $urandom_range(99);
      if (pick < 6) d = 16'($urandom_range(1));
      else if (pick < 80) d = 16'($urandom_range(6, 2));
      else d = 16'($urandom_range(16, 7));
      d[15:DEPTH_W] = 3'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) s = 16'h0000;
      else if (pick < 20) s = 16'hFFFF;
      else s = 16'($urandom);
      wait_idle();
      configure(w, d, s);
   endtask

   task automatic run_frame(input bit broken);
      int total;
      int cut;
      total = row_len() * row_count();
      cut = broken ? $urandom_range(total - 1, 1) : total;
      // nothing is pending yet, so this flush is ignored
      if ($urandom_range(99) < 5) send_item(MODE_FLUSH, 8'($urandom));
      send_samples(cut, 10);
      if (!broken) finish_frame(50);
   endtask

   // ---------------- tests ----------------

   // width and depth below range clamp to 2x2; scale keeps its reset value
   task automatic test_minimum_frame();
      write_reg(REG_MAP_WIDTH, 16'h0000);
      write_reg(REG_MAP_DEPTH, 16'h0001);
      csr_if.valid <= 1'b0;
      send_item(MODE_FLUSH, 8'hFF);
      send_item(MODE_SAMPLE, 8'hFF);
      send_item(MODE_SAMPLE, 8'h00);
      send_item(MODE_SAMPLE, 8'h00);
      send_item(MODE_SAMPLE, 8'hFF);
      finish_frame(100);
   endtask

   // full scale on full samples gives the largest value; surplus samples end the frame
   task automatic test_scale_extremes();
      wait_idle();
      write_reg(REG_HEIGHT_SCALE, 16'hFFFF);
      csr_if.valid <= 1'b0;
      repeat (4) send_item(MODE_SAMPLE, 8'hFF);
      finish_frame(0);
   endtask

   // a write to the unused index leaves the frame running
   task automatic test_unused_register();
      wait_idle();
      send_item(MODE_SAMPLE, 8'($urandom));
      send_item(MODE_SAMPLE, 8'($urandom));
      wait_idle();
      write_reg(REG_UNUSED, 16'hFFFF);
      csr_if.valid <= 1'b0;
      send_samples(2, 0);
      finish_frame(50);
   endtask

   // oversized width and depth clamp to their limits; the frame is cut short
   task automatic test_wide_row();
      wait_idle();
      configure(16'hFFFF, 16'hFFFF, 16'($urandom));
      send_samples(560, 5);
      wait_idle();
   endtask

   task automatic test_stalled_output();
      wait_idle();
      configure(16'd6, 16'd5, 16'($urandom));
      rsp_hold_cycles = 400;
      send_samples(15, 10);
      drain_results();
      send_samples(15, 10);
      finish_frame(50);
   endtask

   task automatic test_full_rate();
      idle_pct = 0;
      repeat (3) begin
         random_config();
         run_frame(1'b0);
      end
      idle_pct = IDLE_PCT;
   endtask

   task automatic test_random_frames();
      bit broken;
      broken = 1'b0;
      while (useful_items < ITEM_TARGET) begin
         // a cut frame needs a register write to restart
         if (broken || $urandom_range(99) < 60) random_config();
         broken = ($urandom_range(99) < 15);
         run_frame(broken);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = MODE_SAMPLE;
      req_if.height_sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_MAP_WIDTH;
      csr_if.data = '0;
      reg_map_width = MAP_WIDTH_RESET;
      reg_map_depth = MAP_DEPTH_RESET;
      reg_height_scale = HEIGHT_SCALE_RESET;
      col_in = 0;
      row_in = 0;
      vertex_pos = 0;
      mismatches = 0;
      useful_items = 0;
      idle_pct = IDLE_PCT;
      rsp_hold_cycles = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_minimum_frame();
      test_scale_extremes();
      test_unused_register();
      test_wide_row();
      test_stalled_output();
      test_full_rate();
      test_random_frames();
      wait_idle();
      if (mismatches == 0 && expected_vertices.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
hdl/hmes_pkg.sv
hdl/hmes_if.sv
hdl/hmes_ctrl.sv
hdl/hmes_datapath.sv
hdl/heightmap_edge_extend_box_smooth_top.sv
hdl/hmes_checker.sv
bench/tb_heightmap_edge_extend_box_smooth_top.sv
